### hw/rtl/pbd_pkg.sv
// Package: shared widths, constants and state types for the pulse beat detector.
`default_nettype none
package pbd_pkg;

  localparam int HISTORY_DEPTH = 30;

  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 32;
  localparam int THRESH_W = 23;
  localparam int RATE_W   = 24;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = RATE_W + FILL_W;

  // Divider works on SUM_W bit dividends, one quotient bit per cycle.
  localparam int DIV_NUM_W = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  // 60000 ms per minute, scaled to Q16.8.
  localparam logic [RATE_W-1:0] RATE_NUMERATOR = RATE_W'(15360000);

  localparam logic [THRESH_W-1:0] LOWER_RESET = THRESH_W'(20);
  localparam logic [THRESH_W-1:0] UPPER_RESET = THRESH_W'(2500);

  // Register select bit of paddr (byte address 4*i).
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  typedef enum logic [2:0] {
    TRK_IDLE    = 3'b001,
    TRK_RISING  = 3'b010,
    TRK_FALLING = 3'b100
  } trk_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RATE = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_MEAN = 5'b01000,
    ST_WAIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic start;
    logic [DIV_NUM_W-1:0] num;
    logic [TIME_W-1:0]    den;
  } div_req_t;

endpackage
`default_nettype wire

### hw/rtl/pbd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module pbd_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pbd_pkg::div_req_t req,
  output logic                  done,
  output logic [pbd_pkg::DIV_NUM_W-1:0] quo
);
  import pbd_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_NUM_W-1:0]  num_r;
  logic [TIME_W-1:0]     den_r;
  logic [TIME_W-1:0]     rem_r;
  logic [TIME_W:0]       trial;
  logic [TIME_W+1:0]     diff;
  logic                  qbit;
  logic [TIME_W-1:0]     rem_nxt;

  // Shift the next dividend bit into the partial remainder, try a subtract.
  assign trial   = {rem_r, num_r[DIV_NUM_W-1]};
  assign diff    = {1'b0, trial} - {2'b00, den_r};
  assign qbit    = ~diff[TIME_W+1];
  assign rem_nxt = qbit ? diff[TIME_W-1:0] : trial[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // Pulse done for one cycle after the last quotient bit.
      done_r <= busy_r && !req.start && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Dividend register turns into the quotient as bits shift through.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

### hw/rtl/pulse_beat_detector_bpm_average_top.sv
// Top level: pulse beat tracker, rate ring with running sum and averaged output.
// An item that marks no beat passes through the WAIT state into the output register.
// A beat item runs bit-serial divisions on one shared divider of DIV_NUM_W (29) steps
// each: the rate, then the mean; when the beat interval is zero the rate division is
// skipped and the rate is zero. One item at a time, so the divider sets the rate.
// Reset (rst_n, synchronous, low) idles the tracker, empties history, restores thresholds.
`default_nettype none
module pulse_beat_detector_bpm_average_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [pbd_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [pbd_pkg::TIME_W-1:0]      in_timestamp_ms,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_beat_detected,
  output logic [pbd_pkg::RATE_W-1:0]           out_average_bpm,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pbd_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [pbd_pkg::DATA_W-1:0]      pwdata,
  output logic [pbd_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);
  import pbd_pkg::*;

  // Configuration registers.
  logic [THRESH_W-1:0] lower_r;
  logic [THRESH_W-1:0] upper_r;
  logic                cfg_wr;

  // Control and tracker state.
  state_t                     state_r;
  trk_t                       trk_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic [TIME_W-1:0]          last_r;
  logic [TIME_W-1:0]          curr_r;

  // History ring and its running sum.
  logic [RATE_W-1:0] hist_r [HISTORY_DEPTH];
  logic [PTR_W-1:0]  ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RATE_W-1:0] mean_r;
  logic [RATE_W-1:0] rate_r;
  logic              beat_r;

  // Output register.
  logic              out_valid_r;
  logic              out_beat_r;
  logic [RATE_W-1:0] out_avg_r;

  logic              accept;
  logic              above_hi;
  logic              below_lo;
  logic              rises;
  logic              beat;
  logic [TIME_W-1:0] interval;
  logic              out_free;
  logic [RATE_W-1:0] old_rate;
  logic [SUM_W-1:0]  sum_nxt;
  logic [FILL_W-1:0] fill_nxt;
  logic [PTR_W-1:0]  ptr_nxt;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // ---------------------------------------------------------------------------
  // Configuration: write on the access cycle, decode on the register select bit.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LOWER: lower_r <= pwdata[THRESH_W-1:0];
        REG_UPPER: upper_r <= pwdata[THRESH_W-1:0];
        default:   lower_r <= lower_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LOWER: prdata = DATA_W'(lower_r);
      REG_UPPER: prdata = DATA_W'(upper_r);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tracker decisions for the item on the input channel.
  // Thresholds are unsigned; compare them against the signed sample.
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign above_hi = in_sample > $signed({1'b0, upper_r});
  assign below_lo = in_sample < $signed({1'b0, lower_r});
  assign rises    = in_sample > prev_r;
  assign beat     = !above_hi && (trk_r == TRK_RISING) && !rises;
  assign interval = curr_r - last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r  <= TRK_IDLE;
      prev_r <= '0;
      last_r <= '0;
      curr_r <= '0;
    end else if (accept) begin
      if (above_hi) begin
        // Overload: drop back to idle and forget the beat times.
        trk_r  <= TRK_IDLE;
        prev_r <= '0;
        last_r <= '0;
        curr_r <= '0;
      end else begin
        unique case (trk_r)
          TRK_RISING: begin
            if (rises) begin
              curr_r <= in_timestamp_ms;
              prev_r <= in_sample;
            end else begin
              // Peak passed: the beat keeps prev_r as it was.
              last_r <= curr_r;
              trk_r  <= TRK_FALLING;
            end
          end
          TRK_FALLING: begin
            if (below_lo) begin
              trk_r <= TRK_IDLE;
            end
            prev_r <= in_sample;
          end
          default: begin
            trk_r  <= below_lo ? TRK_IDLE : TRK_RISING;
            prev_r <= in_sample;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // History ring. Until the ring is full the slot at ptr_r was never written,
  // so it counts as zero; once full, read the rate it held.
  // ---------------------------------------------------------------------------
  assign old_rate = (fill_r == FILL_W'(HISTORY_DEPTH)) ? hist_r[ptr_r] : '0;
  assign sum_nxt  = sum_r - SUM_W'(old_rate) + SUM_W'(rate_r);
  assign fill_nxt = (fill_r == FILL_W'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;
  assign ptr_nxt  = (ptr_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      hist_r[ptr_r] <= rate_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider: rate = numerator / interval, then mean = sum / fill.
  // ---------------------------------------------------------------------------
  always_comb begin
    div_req = '0;
    if (state_r == ST_SUM) begin
      div_req.start = 1'b1;
      div_req.num   = sum_nxt;
      div_req.den   = TIME_W'(fill_nxt);
    end else begin
      div_req.start = accept && beat && (interval != '0);
      div_req.num   = DIV_NUM_W'(RATE_NUMERATOR);
      div_req.den   = interval;
    end
  end

  pbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: one item at a time, result parked in WAIT until the output
  // register is free.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      mean_r  <= '0;
      beat_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            beat_r <= beat;
            if (!beat) begin
              state_r <= ST_WAIT;
            end else if (interval != '0) begin
              state_r <= ST_RATE;
            end else begin
              state_r <= ST_SUM;
            end
          end
        end
        ST_RATE: begin
          if (div_done) begin
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_r   <= sum_nxt;
          fill_r  <= fill_nxt;
          ptr_r   <= ptr_nxt;
          state_r <= ST_MEAN;
        end
        ST_MEAN: begin
          if (div_done) begin
            mean_r  <= div_quo[RATE_W-1:0];
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Rate register: zero for a zero interval, else the divider's quotient.
  always_ff @(posedge clk) begin
    if (accept) begin
      rate_r <= '0;
    end else if (state_r == ST_RATE && div_done) begin
      rate_r <= div_quo[RATE_W-1:0];
    end
  end

  // Output register: hold the result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_WAIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && out_free) begin
      out_beat_r <= beat_r;
      out_avg_r  <= mean_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_beat_detected = out_beat_r;
  assign out_average_bpm   = out_avg_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill count beyond ring depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(HISTORY_DEPTH - 1))
    else $error("history pointer beyond ring depth");

  a_sum_to_mean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |=> state_r == ST_MEAN)
    else $error("sum update not followed by mean division");

  a_beat_has_history: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_beat_r |-> fill_r != '0)
    else $error("beat reported with empty history");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("second item taken while one is in flight");
`endif

endmodule
`default_nettype wire

### verif/tb_top.sv
// Testbench for the pulse beat detector: directed rows, then random pulse trains scored against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import pbd_pkg::*;

  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 240;
  localparam int OPENING_ROWS = 25;
  localparam int STUCK_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 80;
  localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

  // One result item: beat flag and averaged rate.
  typedef struct packed {
    logic              beat;
    logic [RATE_W-1:0] bpm;
  } beat_report_t;

  // One row of the opening table; a typed report is used only where typed_in is set.
  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [TIME_W-1:0]   ms;
    logic                typed_in;
    beat_report_t        report;
  } pulse_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic [TIME_W-1:0]          in_timestamp_ms = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_beat_detected;
  logic [RATE_W-1:0]          out_average_bpm;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  pulse_beat_detector_bpm_average_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_timestamp_ms   (in_timestamp_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_beat_detected (out_beat_detected),
    .out_average_bpm   (out_average_bpm),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow of the block: thresholds, peak tracker and rate ring.
  logic [THRESH_W-1:0]        lower_q;
  logic [THRESH_W-1:0]        upper_q;
  trk_t                       trk;
  logic signed [SAMPLE_W-1:0] prev_level;
  logic [TIME_W-1:0]          last_peak_ms;
  logic [TIME_W-1:0]          peak_ms;
  int unsigned                rate_ring [HISTORY_DEPTH];
  int unsigned                ring_wr;
  int unsigned                ring_fill;
  int unsigned                ring_sum;
  logic [RATE_W-1:0]          avg_bpm;

  beat_report_t               due_reports [$];
  int                         fault_count = 0;
  int                         items_taken = 0;
  logic [TIME_W-1:0]          clock_ms = '0;
  bit                         src_steady = 1'b0;
  bit                         sink_steady = 1'b0;
  int                         sink_stall = 0;
  int                         stuck_cycles = 0;

  // Advance the shadow by one sample and return the result it must produce.
  function automatic beat_report_t predict_beat_rate(input logic signed [SAMPLE_W-1:0] level,
                                                     input logic [TIME_W-1:0] ms);
    beat_report_t               rep;
    logic signed [SAMPLE_W-1:0] lo_s;
    logic signed [SAMPLE_W-1:0] hi_s;
    logic [TIME_W-1:0]          gap_ms;
    int unsigned                rate;
    lo_s = $signed({1'b0, lower_q});
    hi_s = $signed({1'b0, upper_q});
    rep.beat = 1'b0;
    if (level > hi_s) begin
      // Overrange: back to idle, forget the peak times, keep the history.
      trk = TRK_IDLE;
      prev_level = '0;
      last_peak_ms = '0;
      peak_ms = '0;
    end else if (trk == TRK_RISING) begin
      if (level > prev_level) begin
        peak_ms = ms;
        prev_level = level;
      end else begin
        // Beat: rate from the peak interval into the ring; previous level stays.
        gap_ms = peak_ms - last_peak_ms;
        last_peak_ms = peak_ms;
        rate = (gap_ms == 0) ? 0 : 32'(RATE_NUMERATOR) / gap_ms;
        ring_sum = ring_sum - rate_ring[ring_wr] + rate;
        rate_ring[ring_wr] = rate;
        ring_wr = (ring_wr + 1) % HISTORY_DEPTH;
        if (ring_fill < HISTORY_DEPTH) ring_fill++;
        avg_bpm = RATE_W'(ring_sum / ring_fill);
        trk = TRK_FALLING;
        rep.beat = 1'b1;
      end
    end else if (trk == TRK_FALLING) begin
      if (level < lo_s) trk = TRK_IDLE;
      prev_level = level;
    end else begin
      trk = (level >= lo_s) ? TRK_RISING : TRK_IDLE;
      prev_level = level;
    end
    rep.bpm = avg_bpm;
    return rep;
  endfunction

  // Mostly no gap, some short, a few long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  // Time step between samples: usually a few ms, sometimes none, rarely a wild jump.
  function automatic logic [TIME_W-1:0] ms_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 95) return TIME_W'($urandom_range(1, 40));
    if (pick < 99) return TIME_W'($urandom_range(41, 3000));
    return TIME_W'($urandom());
  endfunction

  // Present one item, hold it until taken, then log its expected result.
  // Called and returns at a falling edge.
  task automatic offer_sample(input logic [SAMPLE_W-1:0] level, input logic [TIME_W-1:0] ms,
                              input logic typed_in, input beat_report_t typed_rep);
    beat_report_t rep;
    int           idle;
    if ($urandom_range(0, 99) == 0) src_steady = !src_steady;
    idle = src_steady ? 0 : idle_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= level;
    in_timestamp_ms <= ms;
    do @(posedge clk); while (in_ready !== 1'b1);
    rep = predict_beat_rate(level, ms);
    due_reports.push_back(typed_in ? typed_rep : rep);
    items_taken++;
    @(negedge clk);
  endtask

  task automatic offer_next(input logic [SAMPLE_W-1:0] level);
    clock_ms += ms_step();
    offer_sample(level, clock_ms, 1'b0, '0);
  endtask

  // One pulse: a baseline below the lower threshold, a climb to a peak, a decay back.
  task automatic play_pulse();
    longint lo;
    longint hi;
    longint base;
    longint peak;
    int     n_up;
    int     n_down;
    int     frac;
    int     k;
    lo = lower_q;
    hi = upper_q;
    n_up = $urandom_range(1, 8);
    n_down = $urandom_range(1, 8);
    frac = $urandom_range(0, 3000);
    base = lo - 1 - frac;
    frac = $urandom_range(0, 1000);
    peak = (hi > lo) ? lo + ((hi - lo) * frac) / 1000 : lo;
    offer_next(SAMPLE_W'(base));
    for (k = 1; k <= n_up; k++) offer_next(SAMPLE_W'(lo + ((peak - lo) * k) / n_up));
    for (k = 1; k <= n_down; k++) offer_next(SAMPLE_W'(peak - ((peak - base) * k) / n_down));
  endtask

  // One APB transfer, setup then access; leaves psel high for a back-to-back transfer.
  task automatic apb_access(input logic wr, input logic sel, input logic [DATA_W-1:0] data,
                            output logic [DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
  endtask

  // Write a threshold with junk above bit 22, then read it back.
  task automatic set_threshold(input logic sel, input logic [THRESH_W-1:0] value);
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] echo;
    word = ($urandom() & 32'hFF80_0000) | DATA_W'(value);
    apb_access(1'b1, sel, word, echo);
    if (sel == REG_LOWER) lower_q = value;
    else upper_q = value;
    apb_access(1'b0, sel, '0, echo);
    if (echo !== DATA_W'(value)) begin
      $display("%0t: threshold readback expected %0d, got %0d", $time, value, echo);
      fault_count++;
    end
  endtask

  // Drop valid and wait until every logged result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls with stretches of steady ready.
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) sink_steady <= !sink_steady;
    if (sink_stall != 0) begin
      out_ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      out_ready <= 1'b1;
      sink_stall <= sink_steady ? 0 : idle_len();
    end
  end

  // Score every result item against the oldest expectation.
  always @(posedge clk) begin : score_results
    beat_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: result with none expected: beat %0d bpm %0d", $time,
                 out_beat_detected, out_average_bpm);
        fault_count++;
      end else begin
        want = due_reports.pop_front();
        if (out_beat_detected !== want.beat) begin
          $display("%0t: beat_detected expected %0d, got %0d", $time, want.beat,
                   out_beat_detected);
          fault_count++;
        end
        if (out_average_bpm !== want.bpm) begin
          $display("%0t: average_bpm expected %0d, got %0d", $time, want.bpm,
                   out_average_bpm);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: give up when no handshake of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    pulse_row_t opening [OPENING_ROWS];
    int         row;
    int         phase;
    int         lo_v;
    int         hi_v;
    int         first_item;
    int         pick;
    int         n;
    int         frac;

    // Opening table. Reset thresholds apply: lower 20, upper 2500.
    opening = '{
      '{24'h000000, 32'd0,         1'b1, '{1'b0, 24'd0}},       // below lower, stay idle
      '{24'h800000, 32'd1,         1'b1, '{1'b0, 24'd0}},       // most negative sample
      '{24'd20,     32'd2,         1'b1, '{1'b0, 24'd0}},       // at lower: start rising
      '{24'd100,    32'd10,        1'b1, '{1'b0, 24'd0}},       // higher: peak at 10 ms
      '{24'd100,    32'd12,        1'b1, '{1'b1, 24'd1536000}}, // flat: beat, 10 ms interval
      '{24'd19,     32'd14,        1'b0, '{1'b0, 24'd0}},       // falling ends below lower
      '{24'd2500,   32'd20,        1'b0, '{1'b0, 24'd0}},       // at upper is not above it
      '{24'd2501,   32'd21,        1'b0, '{1'b0, 24'd0}},       // above upper: clear tracker
      '{24'h7FFFFF, 32'd22,        1'b0, '{1'b0, 24'd0}},       // largest sample
      '{24'd50,     32'd30,        1'b0, '{1'b0, 24'd0}},
      '{24'd40,     32'd31,        1'b0, '{1'b0, 24'd0}},       // beat with zero interval
      '{24'hFFFFFB, 32'd32,        1'b0, '{1'b0, 24'd0}},       // negative ends falling
      '{24'd30,     32'hFFFFFFF0,  1'b0, '{1'b0, 24'd0}},
      '{24'd31,     32'hFFFFFFFF,  1'b0, '{1'b0, 24'd0}},       // peak at the last ms
      '{24'd31,     32'd5,         1'b0, '{1'b0, 24'd0}},       // longest interval
      '{24'd25,     32'd6,         1'b0, '{1'b0, 24'd0}},       // falling, still above lower
      '{24'd10,     32'd7,         1'b0, '{1'b0, 24'd0}},
      '{24'd40,     32'd100,       1'b0, '{1'b0, 24'd0}},
      '{24'd41,     32'd9,         1'b0, '{1'b0, 24'd0}},
      '{24'd41,     32'd10,        1'b0, '{1'b0, 24'd0}},       // interval wraps past zero
      '{24'd10,     32'd11,        1'b0, '{1'b0, 24'd0}},
      '{24'd30,     32'd11,        1'b0, '{1'b0, 24'd0}},
      '{24'd31,     32'd10,        1'b0, '{1'b0, 24'd0}},
      '{24'd0,      32'd11,        1'b0, '{1'b0, 24'd0}},       // 1 ms interval: top rate
      '{24'd0,      32'd12,        1'b0, '{1'b0, 24'd0}}
    };

    // Reset the shadow to match the block after reset.
    lower_q = LOWER_RESET;
    upper_q = UPPER_RESET;
    trk = TRK_IDLE;
    prev_level = '0;
    last_peak_ms = '0;
    peak_ms = '0;
    for (row = 0; row < HISTORY_DEPTH; row++) rate_ring[row] = 0;
    ring_wr = 0;
    ring_fill = 0;
    ring_sum = 0;
    avg_bpm = '0;

    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (row = 0; row < OPENING_ROWS; row++) begin
      offer_sample(opening[row].level, opening[row].ms, opening[row].typed_in,
                   opening[row].report);
    end

    // Random phases, each under its own pair of thresholds.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          lo_v = LOWER_RESET;
          hi_v = UPPER_RESET;
        end
        1: begin
          lo_v = 0;
          hi_v = THRESH_MAX;
        end
        2: begin
          lo_v = THRESH_MAX;
          hi_v = THRESH_MAX;
        end
        3: begin
          lo_v = 0;
          hi_v = 0;
        end
        4: begin
          lo_v = $urandom_range(0, 3000);
          hi_v = lo_v + $urandom_range(100, 100000);
        end
        5: begin
          lo_v = $urandom_range(0, THRESH_MAX);
          hi_v = $urandom_range(0, THRESH_MAX);
        end
        default: begin
          lo_v = $urandom_range(0, 200);
          hi_v = $urandom_range(500, 5000);
        end
      endcase
      set_threshold(REG_LOWER, THRESH_W'(lo_v));
      set_threshold(REG_UPPER, THRESH_W'(hi_v));
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clk);

      clock_ms = $urandom();
      first_item = items_taken;
      while (items_taken - first_item < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          play_pulse();
        end else if (pick < 88 && upper_q != THRESH_MAX) begin
          // Overrange spike anywhere above the upper threshold.
          frac = $urandom_range(0, 1000);
          offer_next(SAMPLE_W'(longint'(upper_q) + 1 +
                               ((longint'(THRESH_MAX) - upper_q - 1) * frac) / 1000));
        end else begin
          // Noise: full-range samples.
          for (n = $urandom_range(1, 5); n > 0; n--) offer_next(SAMPLE_W'($urandom()));
        end
      end
    end

    // Wait for the last results, then a short tail to catch strays.
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### pulse_beat_detector_bpm_average_top.f
hw/rtl/pbd_pkg.sv
hw/rtl/pbd_div.sv
hw/rtl/pulse_beat_detector_bpm_average_top.sv
verif/tb_top.sv
